// File: rtl/core/brqs_pkg.sv
// ----------------------------------------------------------------------------
// brqs_pkg: shared types and constants of the byte ring queue or stack
// Mode and status codes, register indexes and the per-beat result record.
// ----------------------------------------------------------------------------
package brqs_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int DATA_W    = 8;
  localparam int MODE_W    = 2;
  localparam int DEPTH_W   = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = DEPTH_W;

  localparam logic [DEPTH_W-1:0] DEPTH_RST = 9'd256;

  // Operating modes; code three behaves as the fifo queue.
  localparam logic [MODE_W-1:0] MODE_FIFO  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STACK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OUT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_WRONG_USE = 2'd3
  } status_e;

  // Result of one beat, handed from the pointer logic to the output stage.
  typedef struct packed {
    status_e           status;
    logic              fwd;
    logic              use_ram;
    logic [DATA_W-1:0] data;
  } result_t;

endpackage

// File: rtl/core/byte_ring_queue_or_stack.sv
// ----------------------------------------------------------------------------
// byte_ring_queue_or_stack: byte ring used as fifo, stack or pass-through
// Result: each accepted input beat yields a registered result beat in the next cycle.
// Throughput: one beat per cycle; a stalled result holds the input side only
//   while out_ready_i stays low (single output register).
// Reset: mode fifo, depth in use 256, write pointer 1, read pointer 0. Ring
//   contents are not cleared; any register write restarts the pointers.
// ----------------------------------------------------------------------------
module byte_ring_queue_or_stack #(
  parameter int DEPTH = brqs_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [brqs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [brqs_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [brqs_pkg::DATA_W-1:0]    data_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [brqs_pkg::DATA_W-1:0]    data_out_o,
  output logic [1:0]                     status_o,
  output logic                           forwarded_o
);

  import brqs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic              in_fire;
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  result_t           res_d;
  result_t           res_q;
  logic              out_valid_q;

  // Take a new beat whenever the result register is free or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Decide the beat, update pointers and issue the ring access.
  brqs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (in_fire),
    .op_i        (op_i),
    .data_i      (data_in_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .res_o       (res_d)
  );

  // Ring storage; read data is registered and lines up with the result
  // register. It only reloads on a read beat, so it holds through a stall.
  brqs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register: load on each accepted beat, hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // Pick the RAM byte for a successful read, else the carried byte.
  assign out_valid_o = out_valid_q;
  assign data_out_o  = res_q.use_ram ? ram_rdata : res_q.data;
  assign status_o    = res_q.status;
  assign forwarded_o = res_q.fwd;

  // A blocked input side means a result is waiting.
  a_ready_low_has_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o
  ) else $error("input stalled without a pending result");

  // Every accepted beat shows up as a result in the next cycle.
  a_fire_gives_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o
  ) else $error("accepted beat produced no result");

  // A forwarded byte always reports ok.
  a_fwd_ok : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && forwarded_o) |-> (status_o == ST_OK)
  ) else $error("forwarded beat with bad status");

  // RAM data is only used by a successful, non-forwarded read.
  a_ram_read_ok : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_q.use_ram) |-> (status_o == ST_OK && !forwarded_o)
  ) else $error("ring byte returned on a failed or forwarded beat");

endmodule

// File: rtl/core/brqs_ram.sv
// ----------------------------------------------------------------------------
// brqs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/brqs_ctrl.sv
// ----------------------------------------------------------------------------
// brqs_ctrl: configuration registers and ring pointer logic
// Decides each beat's outcome, drives the ring RAM and advances the pointers.
// ----------------------------------------------------------------------------
module brqs_ctrl #(
  parameter int DEPTH = brqs_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [brqs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [brqs_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           fire_i,
  input  logic                           op_i,
  input  logic [brqs_pkg::DATA_W-1:0]    data_i,
  output logic                           ram_we_o,
  output logic [$clog2(DEPTH)-1:0]       ram_waddr_o,
  output logic [brqs_pkg::DATA_W-1:0]    ram_wdata_o,
  output logic                           ram_re_o,
  output logic [$clog2(DEPTH)-1:0]       ram_raddr_o,
  output brqs_pkg::result_t              res_o
);

  import brqs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int AD_W  = PTR_W + 1;

  logic [MODE_W-1:0]  mode_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [PTR_W-1:0]   rp_q, rp_d;

  logic [AD_W-1:0]  depth_act;
  logic [PTR_W-1:0] last_slot;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rp_inc;
  logic [PTR_W-1:0] stack_next;

  // Clamp the depth in use to the range 2..DEPTH.
  always_comb begin
    if (depth_q < DEPTH_W'(2)) begin
      depth_act = AD_W'(2);
    end else if (32'(depth_q) > 32'(DEPTH)) begin
      depth_act = AD_W'(DEPTH);
    end else begin
      depth_act = AD_W'(depth_q);
    end
  end

  assign last_slot  = PTR_W'(depth_act - AD_W'(1));
  assign wp_inc     = ({1'b0, wp_q} + AD_W'(1) == depth_act) ? '0 : wp_q + PTR_W'(1);
  assign rp_inc     = ({1'b0, rp_q} + AD_W'(1) == depth_act) ? '0 : rp_q + PTR_W'(1);
  assign stack_next = (wp_q == '0) ? last_slot : wp_q - PTR_W'(1);

  always_comb begin
    wp_d         = wp_q;
    rp_d         = rp_q;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    ram_waddr_o  = wp_q;
    ram_wdata_o  = data_i;
    ram_raddr_o  = rp_inc;
    res_o        = '0;
    res_o.status = ST_OK;

    if (mode_q == MODE_OUT) begin
      if (op_i == OP_WRITE) begin
        res_o.data = data_i;
        res_o.fwd  = 1'b1;
      end else begin
        res_o.status = ST_WRONG_USE;
      end
    end else if (op_i == OP_WRITE) begin
      if (wp_q == rp_q) begin
        res_o.status = ST_OVERFLOW;
      end else begin
        ram_we_o = fire_i;
        wp_d     = wp_inc;
      end
    end else if (mode_q == MODE_STACK) begin
      ram_raddr_o = stack_next;
      if (stack_next == rp_q) begin
        res_o.status = ST_EMPTY;
      end else begin
        ram_re_o      = fire_i;
        res_o.use_ram = 1'b1;
        wp_d          = stack_next;
      end
    end else begin
      if (rp_inc == wp_q) begin
        res_o.status = ST_EMPTY;
      end else begin
        ram_re_o      = fire_i;
        res_o.use_ram = 1'b1;
        rp_d          = rp_inc;
      end
    end
  end

  // Any register write restarts the pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FIFO;
      depth_q <= DEPTH_RST;
      wp_q    <= PTR_W'(1);
      rp_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE: begin
          mode_q <= cfg_wdata_i[MODE_W-1:0];
        end
        CFG_DEPTH: begin
          depth_q <= cfg_wdata_i[DEPTH_W-1:0];
        end
        default: begin
        end
      endcase
      wp_q <= PTR_W'(1);
      rp_q <= '0;
    end else if (fire_i) begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the byte ring queue or stack
// Drives push and pop beats under fifo, stack, pass-through and the spare mode
// code across many ring depths, predicts each result beat in step with the
// accepted inputs and compares it field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
  import brqs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] data;
  } ring_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_e           status;
    logic              fwd;
  } ring_beat_t;

  // DUT ports; every input starts at a known value
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 op_i        = OP_WRITE;
  logic [DATA_W-1:0]    data_in_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [DATA_W-1:0]    data_out_o;
  logic [1:0]           status_o;
  logic                 forwarded_o;

  // Handshake bookkeeping and idling control
  ring_cmd_t  pending_cmds[$];
  ring_beat_t awaited_results[$];
  logic       in_taken    = 1'b0;
  logic       out_taken   = 1'b0;
  logic       rx_hold     = 1'b0;
  logic       hold_req    = 1'b0;
  int         tx_idle_max = 10;
  int         rx_idle_max = 10;
  int         tx_wait     = 0;
  int         rx_wait     = 0;

  // Shadow of the ring: contents, pointers and registers
  logic [DATA_W-1:0]  ring_mem [DEPTH_DEF];
  logic [MODE_W-1:0]  mode_reg  = MODE_FIFO;
  logic [DEPTH_W-1:0] depth_reg = DEPTH_RST;
  logic [8:0]         wr_ptr    = 9'd1;
  logic [8:0]         rd_ptr    = 9'd0;

  // Run statistics
  ring_beat_t  want_beat;
  int          fail_count   = 0;
  int          beats_seen   = 0;
  int          reg_writes   = 0;
  int          n_overflow   = 0;
  int          n_empty      = 0;
  int          n_wrong_use  = 0;
  int          n_forwarded  = 0;
  int unsigned cycle_count  = 0;

  byte_ring_queue_or_stack u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .forwarded_o (forwarded_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Apply one push or pop to the shadow ring and return the beat it yields.
  // Mode three falls through to the fifo rules; depth is clamped to 2..256.
  function automatic ring_beat_t ring_access(input logic op, input logic [DATA_W-1:0] din);
    ring_beat_t res;
    logic [8:0] span;
    logic [8:0] nxt;
    res.data   = '0;
    res.status = ST_OK;
    res.fwd    = 1'b0;
    if (depth_reg < 9'd2) begin
      span = 9'd2;
    end else if (depth_reg > DEPTH_DEF) begin
      span = 9'(DEPTH_DEF);
    end else begin
      span = depth_reg;
    end
    if (wr_ptr >= span) wr_ptr = '0;
    if (rd_ptr >= span) rd_ptr = '0;

    if (mode_reg == MODE_OUT) begin
      if (op == OP_WRITE) begin
        res.data = din;
        res.fwd  = 1'b1;
      end else begin
        res.status = ST_WRONG_USE;
      end
    end else if (op == OP_WRITE) begin
      // full when the write pointer has caught up with the read pointer
      if (wr_ptr == rd_ptr) begin
        res.status = ST_OVERFLOW;
      end else begin
        ring_mem[wr_ptr[7:0]] = din;
        wr_ptr = (wr_ptr + 9'd1) % span;
      end
    end else if (mode_reg == MODE_STACK) begin
      // pop from the top; a write pointer at slot zero wraps to the last slot
      nxt = (wr_ptr == '0) ? span - 9'd1 : wr_ptr - 9'd1;
      if (nxt == rd_ptr) begin
        res.status = ST_EMPTY;
      end else begin
        wr_ptr   = nxt;
        res.data = ring_mem[nxt[7:0]];
      end
    end else begin
      nxt = (rd_ptr + 9'd1) % span;
      if (wr_ptr == nxt) begin
        res.status = ST_EMPTY;
      end else begin
        rd_ptr   = nxt;
        res.data = ring_mem[nxt[7:0]];
      end
    end
    return res;
  endfunction

  // Mostly no wait; otherwise a random stall length drawn from 1..max_wait.
  function automatic int draw_wait(input int max_wait);
    if (max_wait == 0 || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, max_wait);
  endfunction

  // Sample both handshakes at the rising edge: predict on every accepted
  // input beat, check every accepted result beat against the oldest prediction.
  always @(posedge clk_i) begin
    in_taken  <= in_valid_i && in_ready_o;
    out_taken <= out_valid_o && out_ready_i;
    if (!rst_ni) begin
      mode_reg  = MODE_FIFO;
      depth_reg = DEPTH_RST;
      wr_ptr    = 9'd1;
      rd_ptr    = 9'd0;
    end else begin
      // any register write restarts both pointers
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MODE) begin
          mode_reg = cfg_wdata_i[MODE_W-1:0];
        end else if (cfg_idx_i == CFG_DEPTH) begin
          depth_reg = cfg_wdata_i[DEPTH_W-1:0];
        end
        wr_ptr = 9'd1;
        rd_ptr = 9'd0;
        reg_writes++;
      end
      // queue the prediction first so a same-edge result still finds it
      if (in_valid_i && in_ready_o) begin
        awaited_results.push_back(ring_access(op_i, data_in_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result beat: data_out %0d status %0d forwarded %0d",
                 data_out_o, status_o, forwarded_o);
          fail_count++;
        end else begin
          want_beat = awaited_results.pop_front();
          if (data_out_o !== want_beat.data) begin
            $error("data_out mismatch: expected %0d, actual %0d", want_beat.data, data_out_o);
            fail_count++;
          end
          if (status_o !== want_beat.status) begin
            $error("status mismatch: expected %0d, actual %0d", want_beat.status, status_o);
            fail_count++;
          end
          if (forwarded_o !== want_beat.fwd) begin
            $error("forwarded mismatch: expected %0d, actual %0d", want_beat.fwd, forwarded_o);
            fail_count++;
          end
          beats_seen++;
          if (want_beat.status == ST_OVERFLOW) n_overflow++;
          if (want_beat.status == ST_EMPTY) n_empty++;
          if (want_beat.status == ST_WRONG_USE) n_wrong_use++;
          if (want_beat.fwd) n_forwarded++;
        end
      end
    end
  end

  // Input driver: advance at the falling edge once the current beat is taken,
  // after the random gap drawn when that beat was offered.
  always @(negedge clk_i) begin
    ring_cmd_t cmd;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (tx_wait > 0) begin
        in_valid_i <= 1'b0;
        tx_wait--;
      end else if (pending_cmds.size() != 0) begin
        cmd = pending_cmds.pop_front();
        in_valid_i <= 1'b1;
        op_i       <= cmd.op;
        data_in_i  <= cmd.data;
        tx_wait = draw_wait(tx_idle_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: draw a random stall after each taken beat, and drop ready during the hold-off.
  always @(negedge clk_i) begin
    if (out_taken) rx_wait = draw_wait(rx_idle_max);
    if (!rst_ni || rx_hold || rx_wait > 0) begin
      out_ready_i <= 1'b0;
      if (rx_wait > 0) rx_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the output register
  // fills and the block has to stall its input side.
  initial begin
    wait (hold_req);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_beat(input logic op, input logic [DATA_W-1:0] data);
    ring_cmd_t cmd;
    cmd.op   = op;
    cmd.data = data;
    pending_cmds.push_back(cmd);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Wait until every queued beat went in and every result came out, then
  // let the single-register pipeline go quiet.
  task automatic settle();
    while (pending_cmds.size() != 0 || in_valid_i || awaited_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (3) @(negedge clk_i);
  endtask

  // Random beats in bursts of one direction, so the ring runs full and empty,
  // with single random beats mixed in as noise.
  task automatic queue_mixed(input int n_items, input int cap, input logic [MODE_W-1:0] mode_sel);
    int   made;
    int   len;
    logic op;
    made = 0;
    while (made < n_items) begin
      if (mode_sel == MODE_OUT || $urandom_range(0, 4) == 0) begin
        add_beat($urandom_range(0, 1) ? OP_READ : OP_WRITE, 8'($urandom));
        made++;
      end else begin
        op  = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        len = $urandom_range(1, ((cap < 24) ? cap : 24) + 2);
        repeat (len) add_beat(op, 8'($urandom));
        made += len;
      end
    end
  endtask

  initial begin
    logic [MODE_W-1:0]  mode_sel;
    logic [DEPTH_W-1:0] depth_val;
    int                 cap;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: fifo over 256 slots; read empty, push both byte extremes
    add_beat(OP_READ, 8'hFF);
    add_beat(OP_WRITE, 8'h00);
    add_beat(OP_WRITE, 8'hFF);
    add_beat(OP_READ, 8'h00);
    add_beat(OP_READ, 8'h00);
    add_beat(OP_READ, 8'hFF);
    settle();

    // Depth zero is used as two: capacity one, second push overflows
    write_reg(CFG_DEPTH, 9'd0);
    add_beat(OP_WRITE, 8'hA5);
    add_beat(OP_WRITE, 8'h5A);
    add_beat(OP_READ, 8'h00);
    add_beat(OP_READ, 8'h00);
    settle();

    // Stack over three slots: the write pointer wraps to zero, the full push
    // overflows, and the pop from slot zero wraps back to the last slot
    write_reg(CFG_MODE, {7'd0, MODE_STACK});
    write_reg(CFG_DEPTH, 9'd3);
    add_beat(OP_WRITE, 8'h11);
    add_beat(OP_WRITE, 8'h22);
    add_beat(OP_WRITE, 8'h33);
    add_beat(OP_READ, 8'h00);
    add_beat(OP_READ, 8'h00);
    add_beat(OP_READ, 8'h00);
    settle();

    // Spare mode code behaves as fifo; depth one is used as two
    write_reg(CFG_MODE, {7'd0, MODE_SPARE});
    write_reg(CFG_DEPTH, 9'd1);
    add_beat(OP_WRITE, 8'h80);
    add_beat(OP_READ, 8'h7F);
    settle();

    // Pass-through with a depth above the ring: writes forwarded, reads refused
    write_reg(CFG_MODE, {7'h7F, MODE_OUT});
    write_reg(CFG_DEPTH, 9'd511);
    add_beat(OP_WRITE, 8'hFF);
    add_beat(OP_WRITE, 8'h00);
    add_beat(OP_READ, 8'hFF);
    settle();

    // Random phases; one in the middle fills and drains the full ring
    for (int phase = 0; phase < 11; phase++) begin
      tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      if (phase == 5) begin
        mode_sel = $urandom_range(0, 1) ? MODE_STACK : MODE_FIFO;
        write_reg(CFG_MODE, {7'($urandom), mode_sel});
        write_reg(CFG_DEPTH, 9'd256);
        hold_req = 1'b1;
        repeat (256) add_beat(OP_WRITE, 8'($urandom));
        repeat (256) add_beat(OP_READ, 8'($urandom));
        queue_mixed(20, 255, mode_sel);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: mode_sel = MODE_FIFO;
          4, 5, 6, 7: mode_sel = MODE_STACK;
          8:          mode_sel = MODE_OUT;
          default:    mode_sel = MODE_SPARE;
        endcase
        case ($urandom_range(0, 9))
          0:       depth_val = 9'($urandom_range(0, 1));
          1:       depth_val = 9'($urandom_range(257, 511));
          2:       depth_val = 9'($urandom_range(17, 256));
          default: depth_val = 9'($urandom_range(2, 16));
        endcase
        cap = (depth_val < 2) ? 1 : (depth_val > DEPTH_DEF) ? DEPTH_DEF - 1 : depth_val - 1;
        if ($urandom_range(0, 1)) begin
          write_reg(CFG_MODE, {7'($urandom), mode_sel});
          write_reg(CFG_DEPTH, depth_val);
        end else begin
          write_reg(CFG_DEPTH, depth_val);
          write_reg(CFG_MODE, {7'($urandom), mode_sel});
        end
        queue_mixed($urandom_range(8, 20), cap, mode_sel);
      end
      settle();
    end

    repeat (5) @(negedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d result beats never arrived", awaited_results.size());
      fail_count++;
    end

    $display("Checked %0d result beats across %0d register writes (fifo, stack, pass-through).",
             beats_seen, reg_writes);
    $display("Seen: %0d overflow, %0d empty, %0d wrong-use and %0d forwarded beats.",
             n_overflow, n_empty, n_wrong_use, n_forwarded);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
